// ----- sv/midi_event_vlq_serializer_assert.svh -----
// Assertion macros for the MIDI event serializer checker.
// Relies on clk_i and rst_ni being visible where the macros are used.
`ifndef MIDI_EVENT_VLQ_SERIALIZER_ASSERT_SVH
`define MIDI_EVENT_VLQ_SERIALIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define MEVS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define MEVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/mevs_pkg.sv -----
// Shared types and constants for the MIDI event serializer.
// No dependencies.
package mevs_pkg;

  localparam int unsigned TimeW      = 32;
  localparam int unsigned DeltaW     = 28;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned GroupW     = 7;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);
  localparam int unsigned ByteIdxW   = 3;

  localparam logic [DeltaW-1:0] MaxDelta    = 28'hFFF_FFFF;
  localparam logic [GroupW-1:0] GroupMask   = 7'h7F;
  localparam logic              ContinueBit = 1'b1;

  // One classified event: saturated delta, index of its top 7-bit group
  // (number of delta bytes minus one), and the three message bytes.
  typedef struct packed {
    logic [DeltaW-1:0] delta;
    logic [1:0]        top_grp;
    logic [ByteW-1:0]  status_byte;
    logic [ByteW-1:0]  data_one;
    logic [ByteW-1:0]  data_two;
  } vlq_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- sv/mevs_front.sv -----
// Front end: accepts events, computes the saturated delta and byte count.
// Depends on mevs_pkg.
module mevs_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [mevs_pkg::TimeW-1:0] now_ms_i,
  input  logic [mevs_pkg::ByteW-1:0] status_byte_i,
  input  logic [mevs_pkg::ByteW-1:0] data_one_i,
  input  logic [mevs_pkg::ByteW-1:0] data_two_i,
  input  mevs_pkg::q_stat_t        q_stat_i,
  output logic                     push_o,
  output mevs_pkg::vlq_rec_t       rec_o
);

  logic                       started_q, started_d;
  logic [mevs_pkg::TimeW-1:0] prev_time_q, prev_time_d;
  logic [mevs_pkg::TimeW-1:0] raw_delta;
  logic [mevs_pkg::DeltaW-1:0] sat_delta;
  logic [1:0]                 top_grp;

  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    raw_delta = started_q ? (now_ms_i - prev_time_q) : '0;
    // clamp to what four VLQ bytes can carry
    if (|raw_delta[mevs_pkg::TimeW-1:mevs_pkg::DeltaW]) begin
      sat_delta = mevs_pkg::MaxDelta;
    end else begin
      sat_delta = raw_delta[mevs_pkg::DeltaW-1:0];
    end
    if (|sat_delta[27:21]) begin
      top_grp = 2'd3;
    end else if (|sat_delta[20:14]) begin
      top_grp = 2'd2;
    end else if (|sat_delta[13:7]) begin
      top_grp = 2'd1;
    end else begin
      top_grp = 2'd0;
    end
  end

  always_comb begin
    rec_o.delta       = sat_delta;
    rec_o.top_grp     = top_grp;
    rec_o.status_byte = status_byte_i;
    rec_o.data_one    = data_one_i;
    rec_o.data_two    = data_two_i;
  end

  assign started_d   = push_o ? 1'b1 : started_q;
  assign prev_time_d = push_o ? now_ms_i : prev_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      prev_time_q <= '0;
    end else begin
      started_q   <= started_d;
      prev_time_q <= prev_time_d;
    end
  end

endmodule

// ----- sv/mevs_queue.sv -----
// Short event queue between the front end and the byte serializer.
// Depends on mevs_pkg.
module mevs_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mevs_pkg::vlq_rec_t rec_i,
  input  logic               pop_i,
  output mevs_pkg::vlq_rec_t head_o,
  output mevs_pkg::q_stat_t  stat_o
);

  mevs_pkg::vlq_rec_t           entries_q [mevs_pkg::QueueDepth];
  logic [mevs_pkg::QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [mevs_pkg::QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [mevs_pkg::QueueCntW-1:0] count_q, count_d;

  function automatic logic [mevs_pkg::QueuePtrW-1:0] next_ptr(
    input logic [mevs_pkg::QueuePtrW-1:0] ptr
  );
    if (ptr == mevs_pkg::QueuePtrW'(mevs_pkg::QueueDepth - 1)) begin
      return '0;
    end
    return ptr + 1'b1;
  endfunction

  assign stat_o.full  = (count_q == mevs_pkg::QueueCntW'(mevs_pkg::QueueDepth));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

// ----- sv/mevs_back.sv -----
// Back end: walks the queue head into an output register, one byte per cycle unless stalled.
// Depends on mevs_pkg.
module mevs_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mevs_pkg::vlq_rec_t         head_i,
  input  mevs_pkg::q_stat_t          q_stat_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [mevs_pkg::ByteW-1:0] out_byte_o,
  output logic                       last_byte_o
);

  logic [mevs_pkg::ByteIdxW-1:0] byte_idx_q, byte_idx_d;
  logic                          out_valid_q, out_valid_d;
  logic [mevs_pkg::ByteW-1:0]    out_byte_q, out_byte_d;
  logic                          last_byte_q, last_byte_d;
  logic                          load;
  logic [mevs_pkg::ByteIdxW-1:0] top_idx;
  logic [1:0]                    grp;
  logic [mevs_pkg::GroupW-1:0]   grp_bits;
  logic [mevs_pkg::ByteW-1:0]    next_byte;
  logic                          is_last;

  assign load    = (!out_valid_q || out_ready_i) && !q_stat_i.empty;
  assign top_idx = {1'b0, head_i.top_grp};
  assign is_last = (byte_idx_q == top_idx + 3'd3);
  assign pop_o   = load && is_last;
  assign grp     = head_i.top_grp - byte_idx_q[1:0];

  always_comb begin
    case (grp)
      2'd0:    grp_bits = head_i.delta[6:0];
      2'd1:    grp_bits = head_i.delta[13:7];
      2'd2:    grp_bits = head_i.delta[20:14];
      default: grp_bits = head_i.delta[27:21];
    endcase
    grp_bits = grp_bits & mevs_pkg::GroupMask;

    if (byte_idx_q <= top_idx) begin
      // continuation flag on every delta byte but the lowest group
      next_byte = {(grp != 2'd0) & mevs_pkg::ContinueBit, grp_bits};
    end else if (byte_idx_q == top_idx + 3'd1) begin
      next_byte = head_i.status_byte;
    end else if (byte_idx_q == top_idx + 3'd2) begin
      next_byte = head_i.data_one;
    end else begin
      next_byte = head_i.data_two;
    end
  end

  always_comb begin
    byte_idx_d  = byte_idx_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    last_byte_d = last_byte_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_byte_d  = next_byte;
      last_byte_d = is_last;
      byte_idx_d  = is_last ? '0 : byte_idx_q + 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      byte_idx_q  <= byte_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    last_byte_q <= last_byte_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_byte_o = last_byte_q;

endmodule

// ----- sv/midi_event_vlq_serializer.sv -----
// MIDI event serializer: each accepted event comes out as 4 to 7 bytes, one
// byte per cycle from a registered output while out_ready_i takes them: the
// delta time since the previous event (0 for the first one after reset,
// saturated to 0x0FFFFFFF) as a 1 to 4 byte big-endian variable-length
// quantity, then status, data one and data two, with last_byte_o set on data
// two. The output port is the limiting stage; the input side takes events into
// a two-entry queue as long as it has room, so one event may wait while the
// previous one is sent, two once its last byte is in the output register.
// Depends on mevs_pkg, mevs_front, mevs_queue and mevs_back.
module midi_event_vlq_serializer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [mevs_pkg::TimeW-1:0] now_ms_i,
  input  logic [mevs_pkg::ByteW-1:0] status_byte_i,
  input  logic [mevs_pkg::ByteW-1:0] data_one_i,
  input  logic [mevs_pkg::ByteW-1:0] data_two_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [mevs_pkg::ByteW-1:0] out_byte_o,
  output logic                       last_byte_o
);

  mevs_pkg::q_stat_t  q_stat;
  mevs_pkg::vlq_rec_t push_rec;
  mevs_pkg::vlq_rec_t head_rec;
  logic               push;
  logic               pop;

  mevs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .now_ms_i      (now_ms_i),
    .status_byte_i (status_byte_i),
    .data_one_i    (data_one_i),
    .data_two_i    (data_two_i),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .rec_o         (push_rec)
  );

  mevs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (push_rec),
    .pop_i  (pop),
    .head_o (head_rec),
    .stat_o (q_stat)
  );

  mevs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_rec),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

// ----- sv/mevs_checker.sv -----
// Port-level checker for the MIDI event serializer, bound to the top level.
// Depends on mevs_pkg and midi_event_vlq_serializer_assert.svh.
`include "midi_event_vlq_serializer_assert.svh"

module mevs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [mevs_pkg::ByteW-1:0] out_byte_o,
  input logic                       last_byte_o
);

  // events taken in whose final byte has not yet been delivered
  logic [2:0] pending_q, pending_d;
  logic       in_xfer, last_xfer;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign last_xfer = out_valid_o && out_ready_i && last_byte_o;

  always_comb begin
    pending_d = pending_q;
    if (in_xfer && !last_xfer) begin
      pending_d = pending_q + 1'b1;
    end else if (last_xfer && !in_xfer) begin
      pending_d = pending_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  `MEVS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_byte_o) && $stable(last_byte_o),
    "stalled output byte changed")

  `MEVS_ASSERT_NOW(a_no_spurious_out, out_valid_o, pending_q != 3'd0,
    "output byte with no event outstanding")

  `MEVS_ASSERT_NOW(a_bounded_backlog, 1'b1, pending_q <= 3'd3,
    "more events outstanding than queue and output can hold")

  `MEVS_ASSERT_NOW(a_full_blocks_input, pending_q == 3'd3 && !last_xfer, !in_ready_o,
    "input accepted with queue full")

endmodule

bind midi_event_vlq_serializer mevs_checker u_mevs_checker (.*);

// ----- verif/midi_byte_checker.sv -----
`timescale 1ns / 100ps
// Byte-stream checker for the MIDI event serializer: watches both channels,
// predicts the track bytes of each accepted event and compares them in order.
// Depends on mevs_pkg for widths and encoding constants.
module midi_byte_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [mevs_pkg::TimeW-1:0] now_ms_i,
  input  logic [mevs_pkg::ByteW-1:0] status_byte_i,
  input  logic [mevs_pkg::ByteW-1:0] data_one_i,
  input  logic [mevs_pkg::ByteW-1:0] data_two_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [mevs_pkg::ByteW-1:0] out_byte_i,
  input  logic                       last_byte_i,
  output int                         mismatch_count_o,
  output int                         pending_count_o
);

  typedef struct packed {
    logic [mevs_pkg::ByteW-1:0] value;
    logic                       last_flag;
  } track_byte_t;

  track_byte_t                track_bytes[$];
  logic                       seen_first;
  logic [mevs_pkg::TimeW-1:0] prev_stamp;
  int                         mismatches;

  // Append the delta VLQ and the three message bytes of one event.
  function automatic void queue_track_bytes(input logic [mevs_pkg::TimeW-1:0] stamp,
                                            input logic [mevs_pkg::ByteW-1:0] status,
                                            input logic [mevs_pkg::ByteW-1:0] first,
                                            input logic [mevs_pkg::ByteW-1:0] second);
    logic [mevs_pkg::TimeW-1:0]  gap_ms;
    logic [mevs_pkg::DeltaW-1:0] delta;
    logic [mevs_pkg::GroupW-1:0] grp;
    track_byte_t                 tb_byte;
    int                          top;
    gap_ms = seen_first ? stamp - prev_stamp : '0;
    seen_first = 1'b1;
    prev_stamp = stamp;
    delta = (gap_ms > mevs_pkg::TimeW'(mevs_pkg::MaxDelta)) ? mevs_pkg::MaxDelta
                                                             : gap_ms[mevs_pkg::DeltaW-1:0];
    top = 0;
    for (int g = 1; g < 4; g++) begin
      if ((delta >> (mevs_pkg::GroupW * g)) != 0) top = g;
    end
    // Most significant group first; continuation bit on all but the last.
    for (int g = top; g >= 0; g--) begin
      grp = delta[mevs_pkg::GroupW*g +: mevs_pkg::GroupW] & mevs_pkg::GroupMask;
      tb_byte.value = {(g > 0) ? mevs_pkg::ContinueBit : 1'b0, grp};
      tb_byte.last_flag = 1'b0;
      track_bytes.push_back(tb_byte);
    end
    track_bytes.push_back('{value: status, last_flag: 1'b0});
    track_bytes.push_back('{value: first,  last_flag: 1'b0});
    track_bytes.push_back('{value: second, last_flag: 1'b1});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    track_byte_t want;
    if (!rst_ni) begin
      track_bytes.delete();
      seen_first = 1'b0;
      prev_stamp = '0;
      mismatches = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        queue_track_bytes(now_ms_i, status_byte_i, data_one_i, data_two_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (track_bytes.size() == 0) begin
          $error("out_byte: unexpected transaction, actual 0x%02h last %0b",
                 out_byte_i, last_byte_i);
          mismatches++;
        end else begin
          want = track_bytes.pop_front();
          if (out_byte_i !== want.value) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", want.value, out_byte_i);
            mismatches++;
          end
          if (last_byte_i !== want.last_flag) begin
            $error("last_byte: expected %0b, actual %0b", want.last_flag, last_byte_i);
            mismatches++;
          end
        end
      end
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= track_bytes.size();
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the MIDI event serializer: drives directed and random
// events with random idling on both channels and gives the verdict.
// Depends on mevs_pkg, midi_byte_checker and the serializer RTL.
module tb;

  localparam int RandomEvents = 460;
  localparam int CycleLimit   = 600000;
  localparam int DrainCycles  = 20;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       in_valid_i    = 1'b0;
  logic                       in_ready_o;
  logic [mevs_pkg::TimeW-1:0] now_ms_i      = '0;
  logic [mevs_pkg::ByteW-1:0] status_byte_i = '0;
  logic [mevs_pkg::ByteW-1:0] data_one_i    = '0;
  logic [mevs_pkg::ByteW-1:0] data_two_i    = '0;
  logic                       out_valid_o;
  logic                       out_ready_i   = 1'b0;
  logic [mevs_pkg::ByteW-1:0] out_byte_o;
  logic                       last_byte_o;

  int                         mismatch_count;
  int                         pending_bytes;
  int                         cycle_count   = 0;
  logic [mevs_pkg::TimeW-1:0] clock_ms      = '0;
  int                         burst_events  = 0;

  midi_event_vlq_serializer u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .now_ms_i, .status_byte_i,
    .data_one_i, .data_two_i, .out_valid_o, .out_ready_i, .out_byte_o, .last_byte_o
  );

  midi_byte_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .now_ms_i, .status_byte_i,
    .data_one_i, .data_two_i, .out_valid_i(out_valid_o), .out_ready_i,
    .out_byte_i(out_byte_o), .last_byte_i(last_byte_o),
    .mismatch_count_o(mismatch_count), .pending_count_o(pending_bytes)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Sink side: quiet stretches with no stalls and stall-heavy ones follow in random order.
  always @(posedge clk_i) begin
    int stall_left;
    int mode_left;
    logic stalling_mode;
    if (mode_left <= 0) begin
      mode_left = $urandom_range(100, 400);
      stalling_mode = ($urandom_range(0, 2) != 0);
    end
    mode_left--;
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (stalling_mode && $urandom_range(0, 99) < 25) begin
      case ($urandom_range(0, 19)) inside
        0:       stall_left = $urandom_range(10, 30);
        [1:3]:   stall_left = $urandom_range(3, 6);
        default: stall_left = $urandom_range(0, 1);
      endcase
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Call right after a rising edge; returns right after the accepting edge.
  task automatic send_event(input logic [mevs_pkg::TimeW-1:0] stamp,
                            input logic [mevs_pkg::ByteW-1:0] status,
                            input logic [mevs_pkg::ByteW-1:0] first,
                            input logic [mevs_pkg::ByteW-1:0] second);
    int gap;
    if (burst_events > 0) begin
      burst_events--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 29) == 0) burst_events = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    now_ms_i      <= stamp;
    status_byte_i <= status;
    data_one_i    <= first;
    data_two_i    <= second;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_after(input logic [mevs_pkg::TimeW-1:0] delta_ms,
                            input logic [mevs_pkg::ByteW-1:0] status,
                            input logic [mevs_pkg::ByteW-1:0] first,
                            input logic [mevs_pkg::ByteW-1:0] second);
    clock_ms = clock_ms + delta_ms;
    send_event(clock_ms, status, first, second);
  endtask

  function automatic logic [mevs_pkg::TimeW-1:0] pick_delta();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom_range(0, 32'h7F);
    if (r < 48) return $urandom_range(32'h80, 32'h3FFF);
    if (r < 63) return $urandom_range(32'h4000, 32'h1F_FFFF);
    if (r < 76) return $urandom_range(32'h20_0000, 32'h0FFF_FFFF);
    if (r < 84) return $urandom_range(32'h0FFF_FFF0, 32'h1000_000F);
    if (r < 92) return $urandom();
    case ($urandom_range(0, 5))
      0:       return 32'h7F  + $urandom_range(0, 1);
      1:       return 32'h3FFF + $urandom_range(0, 1);
      2:       return 32'h1F_FFFF + $urandom_range(0, 1);
      3:       return 32'h0FFF_FFFF;
      4:       return 32'hFFFF_FFFF;
      default: return 32'h8000_0000;
    endcase
  endfunction

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First event at time zero still gets a zero delta.
    send_event(32'h0, 8'h90, 8'h24, 8'h7F);
    send_after(32'h0, 8'h00, 8'h00, 8'h00);
    send_after(32'h7F, 8'hFF, 8'hFF, 8'hFF);
    send_after(32'h80, 8'h80, 8'h7F, 8'h80);
    send_after(32'h3FFF, 8'h99, 8'h26, 8'h01);
    send_after(32'h4000, 8'hB0, 8'h55, 8'hAA);
    send_after(32'h1F_FFFF, 8'hC0, 8'hAA, 8'h55);
    send_after(32'h20_0000, 8'hE0, 8'h01, 8'h40);
    send_after(32'h0FFF_FFFF, 8'hF0, 8'h80, 8'h00);
    // Saturation, then time going backwards.
    send_after(32'h1000_0000, 8'h89, 8'h2A, 8'h00);
    send_after(32'hFFFF_FFFF, 8'h55, 8'h33, 8'hCC);
    send_event(32'hFFFF_FFFF, 8'hAA, 8'hCC, 8'h33);
    clock_ms = 32'hFFFF_FFFF;
    // Wrap through zero gives a small delta.
    send_after(32'h6, 8'h90, 8'h7F, 8'h7F);
    send_after(32'h0FFF_FFFE, 8'h80, 8'h00, 8'hFF);
    send_after(32'h8000_0000, 8'h7F, 8'hFE, 8'h01);
    send_after(32'h0, 8'h01, 8'h02, 8'h04);

    for (int n = 0; n < RandomEvents; n++) begin
      send_after(pick_delta(), mevs_pkg::ByteW'($urandom_range(0, 255)),
                 mevs_pkg::ByteW'($urandom_range(0, 255)),
                 mevs_pkg::ByteW'($urandom_range(0, 255)));
    end
    in_valid_i <= 1'b0;

    // let the checker count the bytes of the last transaction before draining
    @(posedge clk_i);
    while (pending_bytes != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
